@@ rtl/core/ber_tlv_header_parser_macros.svh @@
// ----------------------------------------------------------------------------
// ber_tlv_header_parser_macros.svh
// Assertion macros shared by the header parser files.
// ----------------------------------------------------------------------------
`ifndef BER_TLV_HEADER_PARSER_MACROS_SVH
`define BER_TLV_HEADER_PARSER_MACROS_SVH

`ifndef ASSERT_OFF

// concurrent check on clk_i, disabled while rst_ni is low
`define BTLV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// concurrent check on clk_i that also holds during reset
`define BTLV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define BTLV_ASSERT(lbl, prop, msg)
`define BTLV_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/core/btlv_pkg.sv @@
// ----------------------------------------------------------------------------
// btlv_pkg
// Types and constants shared by the BER-TLV header parser.
// ----------------------------------------------------------------------------
package btlv_pkg;

  // tag and length byte masks
  localparam logic [7:0] TagConsMask  = 8'h20;
  localparam logic [7:0] TagMultiMask = 8'h1F;
  localparam logic [7:0] LenLongMask  = 8'h80;
  localparam logic [7:0] LenCountMask = 8'h7F;

  localparam logic [3:0] DepthMax = 4'd15;

  // error codes of a result
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TAG_LONG = 2'd1,
    ERR_LEN_LONG = 2'd2,
    ERR_INDEF    = 2'd3
  } btlv_err_e;

  // one parsed header
  typedef struct packed {
    logic [31:0] tag_value;
    logic [2:0]  tag_byte_count;
    logic        constructed;
    logic [31:0] hdr_length;
    logic        long_form;
    logic [3:0]  nesting_depth;
    btlv_err_e   error_code;
  } btlv_result_t;

endpackage

@@ rtl/core/ber_tlv_header_parser.sv @@
// ----------------------------------------------------------------------------
// ber_tlv_header_parser
// BER-TLV tag and length header parser for a byte stream.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and, for each complete or failed header,
// gives one result transfer with tag, constructed bit, length, nesting depth
// and error code; bytes that complete nothing give no result. A byte waits
// in the input register until the pipeline advances; then the header state
// updates and the result register loads together, so the result of the byte
// that completes a header is registered before it reaches the outputs. The
// sustained rate is one byte per cycle while the result side does not stall,
// as the header state registers update on each stepped byte; a stall on the
// result side holds the input side once the input register is full.
`include "ber_tlv_header_parser_macros.svh"

module ber_tlv_header_parser #(
  parameter int MAX_TAG_BYTES    = 4,
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_message_i,
  // header result
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] tag_value_o,
  output logic [2:0]  tag_byte_count_o,
  output logic        constructed_o,
  output logic [31:0] hdr_length_o,
  output logic        long_form_o,
  output logic [3:0]  nesting_depth_o,
  output logic [1:0]  error_code_o
);
  import btlv_pkg::*;

  logic         in_valid_q, in_valid_d;
  logic [7:0]   in_byte_q;
  logic         in_start_q;
  logic         out_valid_q, out_valid_d;
  btlv_result_t out_res_q;

  logic         advance;
  logic         step;
  logic         in_xfer;
  logic         res_valid;
  btlv_result_t res;

  // pipeline moves unless a result is held by the consumer
  assign advance    = !(out_valid_q && out_stall_i);
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q  <= data_byte_i;
      in_start_q <= start_message_i;
    end
  end

  // header state machine
  btlv_parser #(
    .MAX_TAG_BYTES   (MAX_TAG_BYTES),
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .data_byte_i    (in_byte_q),
    .start_message_i(in_start_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // result register
  assign out_valid_d = advance ? res_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign tag_value_o      = out_res_q.tag_value;
  assign tag_byte_count_o = out_res_q.tag_byte_count;
  assign constructed_o    = out_res_q.constructed;
  assign hdr_length_o     = out_res_q.hdr_length;
  assign long_form_o      = out_res_q.long_form;
  assign nesting_depth_o  = out_res_q.nesting_depth;
  assign error_code_o     = out_res_q.error_code;

  // input side stalls only behind a held result
  `BTLV_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> (out_valid_q && out_stall_i), "input stalled without a held result")
  // a held result is not dropped
  `BTLV_ASSERT(a_out_held, (out_valid_q && out_stall_i) |=> out_valid_q, "held result dropped")
  // a waiting byte is not dropped while the pipeline is held
  `BTLV_ASSERT(a_in_held, (in_valid_q && !advance) |=> in_valid_q, "waiting byte dropped")
  // the parser steps only when its result can be taken
  `BTLV_ASSERT_ALWAYS(a_step_room, res_valid |-> advance, "result produced without room")

endmodule

@@ rtl/core/btlv_parser.sv @@
// ----------------------------------------------------------------------------
// btlv_parser
// Header state machine: takes one byte per step and returns the header
// result that this byte completes, if any.
// ----------------------------------------------------------------------------
`include "ber_tlv_header_parser_macros.svh"

module btlv_parser #(
  parameter int MAX_TAG_BYTES    = 4,
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  start_message_i,
  output logic                  res_valid_o,
  output btlv_pkg::btlv_result_t res_o
);
  import btlv_pkg::*;

  localparam int TagCntW = $clog2(MAX_TAG_BYTES + 1);
  localparam int LenCntW = $clog2(MAX_LENGTH_BYTES + 1);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TAG_FIRST = 3'd1,
    PH_TAG_MORE  = 3'd2,
    PH_LEN_FIRST = 3'd3,
    PH_LEN_MORE  = 3'd4
  } phase_e;

  phase_e              phase_q, phase_d, phase_eff;
  logic [31:0]         tag_acc_q, tag_acc_d;
  logic [TagCntW-1:0]  tag_cnt_q, tag_cnt_d;
  logic [31:0]         len_acc_q, len_acc_d;
  logic [LenCntW-1:0]  len_left_q, len_left_d;
  logic                cons_q, cons_d;
  logic [3:0]          depth_q, depth_d, depth_eff;

  logic [31:0]         len_shift;
  logic [LenCntW-1:0]  len_left_dec;
  logic [6:0]          len_n;
  logic [3:0]          tag_cnt_ext;
  logic                emit;
  logic [31:0]         emit_len;
  logic                emit_lf;
  btlv_err_e           emit_err;
  logic                hdr_done;

  assign tag_cnt_ext  = 4'(tag_cnt_q);
  assign len_shift    = {len_acc_q[23:0], data_byte_i};
  assign len_left_dec = (len_left_q != '0) ? len_left_q - 1'b1 : len_left_q;
  assign len_n        = data_byte_i[6:0] & LenCountMask[6:0];

  // next-state and result logic for one byte
  always_comb begin
    phase_eff  = start_message_i ? PH_TAG_FIRST : phase_q;
    depth_eff  = start_message_i ? 4'd0 : depth_q;
    phase_d    = phase_eff;
    depth_d    = depth_eff;
    tag_acc_d  = tag_acc_q;
    tag_cnt_d  = tag_cnt_q;
    len_acc_d  = len_acc_q;
    len_left_d = len_left_q;
    cons_d     = cons_q;
    emit       = 1'b0;
    emit_len   = '0;
    emit_lf    = 1'b0;
    emit_err   = ERR_NONE;
    hdr_done   = 1'b0;

    unique case (phase_eff)
      PH_TAG_FIRST: begin
        tag_acc_d  = {24'd0, data_byte_i};
        tag_cnt_d  = TagCntW'(1);
        cons_d     = (data_byte_i & TagConsMask) != 8'd0;
        len_acc_d  = '0;
        len_left_d = '0;
        phase_d    = ((data_byte_i & TagMultiMask) == TagMultiMask) ? PH_TAG_MORE
                                                                    : PH_LEN_FIRST;
      end
      PH_TAG_MORE: begin
        if (tag_cnt_q >= TagCntW'(MAX_TAG_BYTES)) begin
          emit     = 1'b1;
          emit_err = ERR_TAG_LONG;
          phase_d  = PH_IDLE;
        end else begin
          tag_acc_d = {tag_acc_q[23:0], data_byte_i};
          tag_cnt_d = tag_cnt_q + 1'b1;
          if ((data_byte_i & LenLongMask) == 8'd0) begin
            phase_d = PH_LEN_FIRST;
          end
        end
      end
      PH_LEN_FIRST: begin
        if ((data_byte_i & LenLongMask) == 8'd0) begin
          emit     = 1'b1;
          emit_len = {24'd0, data_byte_i};
          hdr_done = 1'b1;
        end else if (len_n == 7'd0) begin
          emit     = 1'b1;
          emit_lf  = 1'b1;
          emit_err = ERR_INDEF;
          phase_d  = PH_IDLE;
        end else if (len_n > 7'(MAX_LENGTH_BYTES)) begin
          emit     = 1'b1;
          emit_lf  = 1'b1;
          emit_err = ERR_LEN_LONG;
          phase_d  = PH_IDLE;
        end else begin
          len_acc_d  = '0;
          len_left_d = LenCntW'(len_n);
          phase_d    = PH_LEN_MORE;
        end
      end
      PH_LEN_MORE: begin
        len_acc_d  = len_shift;
        len_left_d = len_left_dec;
        if (len_left_dec == '0) begin
          emit     = 1'b1;
          emit_len = len_shift;
          emit_lf  = 1'b1;
          hdr_done = 1'b1;
        end
      end
      PH_IDLE: begin
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // header complete: go one level deeper or stop until the next start
    if (hdr_done) begin
      if (cons_q) begin
        phase_d = PH_TAG_FIRST;
        if (depth_eff < DepthMax) begin
          depth_d = depth_eff + 4'd1;
        end
      end else begin
        phase_d = PH_IDLE;
      end
    end
  end

  // result of the current byte
  assign res_valid_o          = step_i && emit;
  assign res_o.tag_value      = tag_acc_q;
  assign res_o.tag_byte_count = tag_cnt_ext[2:0];
  assign res_o.constructed    = cons_q;
  assign res_o.hdr_length     = emit_len;
  assign res_o.long_form      = emit_lf;
  assign res_o.nesting_depth  = depth_eff;
  assign res_o.error_code     = emit_err;

  // parser state, updated on each stepped byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tag_acc_q  <= '0;
      tag_cnt_q  <= '0;
      len_acc_q  <= '0;
      len_left_q <= '0;
      cons_q     <= 1'b0;
      depth_q    <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      tag_acc_q  <= tag_acc_d;
      tag_cnt_q  <= tag_cnt_d;
      len_acc_q  <= len_acc_d;
      len_left_q <= len_left_d;
      cons_q     <= cons_d;
      depth_q    <= depth_d;
    end
  end

  // an error result always leaves the parser idle
  `BTLV_ASSERT(a_err_idles, (res_valid_o && (res_o.error_code != ERR_NONE)) |=> (phase_q == PH_IDLE), "error result did not idle the parser")
  // a good constructed header always opens a nested header
  `BTLV_ASSERT(a_cons_nests, (res_valid_o && (res_o.error_code == ERR_NONE) && res_o.constructed) |=> (phase_q == PH_TAG_FIRST), "constructed header did not nest")
  // length byte counter stays in range while collecting length bytes
  `BTLV_ASSERT(a_len_left_range, (phase_q == PH_LEN_MORE) |-> ((len_left_q != '0) && (len_left_q <= LenCntW'(MAX_LENGTH_BYTES))), "length byte counter out of range")
  // tag byte counter never exceeds the tag limit
  `BTLV_ASSERT(a_tag_cnt_range, tag_cnt_q <= TagCntW'(MAX_TAG_BYTES), "tag byte counter out of range")

endmodule
